FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// expects clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on the rising clock edge, off during reset
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication sampled on the rising clock edge, off during reset
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

FILE: rtl/pljac_pkg.sv
// types, widths and constants of the pose/landmark jacobian pipeline
// no dependencies
package pljac_pkg;

    // field widths
    localparam int POS_W = 32;   // Q16.16 positions
    localparam int HDG_W = 31;   // Q3.28 heading
    localparam int OUT_W = 32;   // result fields
    localparam int DW    = 33;   // position differences
    localparam int XYW   = 33;   // cordic x / y datapath
    localparam int ZW    = 34;   // cordic angle datapath (Q4.30)
    localparam int PW    = OUT_W + DW;  // trig term times difference
    localparam int SW    = PW + 1;      // sum of two products

    // fixed point constants
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint ROUND_HALF  = 64'sd536870912;
    localparam int     FRAC_SHIFT  = 30;
    localparam int     ATAN_LEN    = 30;

    // state carried through the rotation stages
    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  flip;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
    } cordic_t;

    // rounded arctangent of 2^-idx in Q4.30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            5'd0:    val = ZW'(64'sd843314857);
            5'd1:    val = ZW'(64'sd497837829);
            5'd2:    val = ZW'(64'sd263043837);
            5'd3:    val = ZW'(64'sd133525159);
            5'd4:    val = ZW'(64'sd67021687);
            5'd5:    val = ZW'(64'sd33543516);
            5'd6:    val = ZW'(64'sd16775851);
            5'd7:    val = ZW'(64'sd8388437);
            5'd8:    val = ZW'(64'sd4194283);
            5'd9:    val = ZW'(64'sd2097149);
            5'd10:   val = ZW'(64'sd1048576);
            5'd11:   val = ZW'(64'sd524288);
            5'd12:   val = ZW'(64'sd262144);
            5'd13:   val = ZW'(64'sd131072);
            5'd14:   val = ZW'(64'sd65536);
            5'd15:   val = ZW'(64'sd32768);
            5'd16:   val = ZW'(64'sd16384);
            5'd17:   val = ZW'(64'sd8192);
            5'd18:   val = ZW'(64'sd4096);
            5'd19:   val = ZW'(64'sd2048);
            5'd20:   val = ZW'(64'sd1024);
            5'd21:   val = ZW'(64'sd512);
            5'd22:   val = ZW'(64'sd256);
            5'd23:   val = ZW'(64'sd128);
            5'd24:   val = ZW'(64'sd64);
            5'd25:   val = ZW'(64'sd32);
            5'd26:   val = ZW'(64'sd16);
            5'd27:   val = ZW'(64'sd8);
            5'd28:   val = ZW'(64'sd4);
            5'd29:   val = ZW'(64'sd2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/pljac_front.sv
// input stage: half-turn fold of the heading and position differences
// depends on pljac_pkg
module pljac_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    output logic                                ready_out,
    input  logic signed [pljac_pkg::POS_W-1:0]  pose_x,
    input  logic signed [pljac_pkg::POS_W-1:0]  pose_y,
    input  logic signed [pljac_pkg::HDG_W-1:0]  pose_heading,
    input  logic signed [pljac_pkg::POS_W-1:0]  point_x,
    input  logic signed [pljac_pkg::POS_W-1:0]  point_y,
    output pljac_pkg::cordic_t                  data_out,
    output logic                                valid_out,
    input  logic                                ready_in
);
    import pljac_pkg::*;

    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q30);

    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [ZW-1:0] z_ext;
    logic signed [ZW-1:0] z_q30;

    // heading to Q4.30, fold into the right half plane
    always_comb
    begin
        z_ext          = ZW'(pose_heading);
        z_q30          = z_ext <<< 2;
        data_next.x    = XYW'(GAIN_Q30);
        data_next.y    = '0;
        data_next.dx   = DW'(point_x) - DW'(pose_x);
        data_next.dy   = DW'(point_y) - DW'(pose_y);
        priority if (z_q30 > HALF_PI_Z)
        begin
            data_next.z    = z_q30 - PI_Z;
            data_next.flip = 1'b1;
        end
        else if (z_q30 < -HALF_PI_Z)
        begin
            data_next.z    = z_q30 + PI_Z;
            data_next.flip = 1'b1;
        end
        else
        begin
            data_next.z    = z_q30;
            data_next.flip = 1'b0;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
            data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

FILE: rtl/pljac_cordic_stage.sv
// one registered rotation step of the sine/cosine cordic
// depends on pljac_pkg
module pljac_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pljac_pkg::cordic_t  data_in,
    input  logic                valid_in,
    output logic                ready_out,
    output pljac_pkg::cordic_t  data_out,
    output logic                valid_out,
    input  logic                ready_in
);
    import pljac_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_K = atan_q30(5'(IDX));

    logic                  valid_reg;
    cordic_t               data_reg;
    cordic_t               data_next;
    logic signed [XYW-1:0] x_in;
    logic signed [XYW-1:0] y_in;
    logic signed [XYW-1:0] x_sh;
    logic signed [XYW-1:0] y_sh;

    // rotate toward zero residual angle
    always_comb
    begin
        x_in      = data_in.x;
        y_in      = data_in.y;
        x_sh      = x_in >>> IDX;
        y_sh      = y_in >>> IDX;
        data_next = data_in;
        if (!data_in.z[ZW-1])
        begin
            data_next.x = x_in - y_sh;
            data_next.y = y_in + x_sh;
            data_next.z = data_in.z - ATAN_K;
        end
        else
        begin
            data_next.x = x_in + y_sh;
            data_next.y = y_in - x_sh;
            data_next.z = data_in.z + ATAN_K;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
            data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

FILE: rtl/pljac_mix.sv
// back end: trig clamp, four products, round and saturate of the mixed terms
// depends on pljac_pkg
module pljac_mix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pljac_pkg::cordic_t                  data_in,
    input  logic                                valid_in,
    output logic                                ready_out,
    output logic signed [pljac_pkg::OUT_W-1:0]  cos_out,
    output logic signed [pljac_pkg::OUT_W-1:0]  sin_out,
    output logic signed [pljac_pkg::OUT_W-1:0]  mix_a,
    output logic signed [pljac_pkg::OUT_W-1:0]  mix_b,
    output logic                                valid_out,
    input  logic                                ready_in
);
    import pljac_pkg::*;

    localparam logic signed [XYW:0]  ONE_P   = (XYW+1)'(ONE_Q30);
    localparam logic signed [SW-1:0] ROUND_S = SW'(ROUND_HALF);
    localparam logic signed [SW-1:0] MAX_S   = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] MIN_S   = SW'(-64'sd2147483648);

    // clamp a folded cordic output to plus or minus one
    function automatic logic signed [OUT_W-1:0] clamp_one(input logic signed [XYW:0] v);
        logic signed [OUT_W-1:0] r;
        priority if (v > ONE_P)
            r = OUT_W'(ONE_P);
        else if (v < -ONE_P)
            r = OUT_W'(-ONE_P);
        else
            r = OUT_W'(v);
        return r;
    endfunction

    // round half up, drop fraction, saturate to the output width
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]    q;
        logic signed [OUT_W-1:0] r;
        q = (v + ROUND_S) >>> FRAC_SHIFT;
        priority if (q > MAX_S)
            r = OUT_W'(MAX_S);
        else if (q < MIN_S)
            r = OUT_W'(MIN_S);
        else
            r = OUT_W'(q);
        return r;
    endfunction

    // clamp stage
    logic                    t_valid_reg;
    logic signed [OUT_W-1:0] t_cos_reg;
    logic signed [OUT_W-1:0] t_sin_reg;
    logic signed [DW-1:0]    t_dx_reg;
    logic signed [DW-1:0]    t_dy_reg;
    logic signed [XYW:0]     x_fold;
    logic signed [XYW:0]     y_fold;
    logic                    t_ready;

    // product stage
    logic                    p_valid_reg;
    logic signed [OUT_W-1:0] p_cos_reg;
    logic signed [OUT_W-1:0] p_sin_reg;
    logic signed [PW-1:0]    p_cdy_reg;
    logic signed [PW-1:0]    p_sdx_reg;
    logic signed [PW-1:0]    p_sdy_reg;
    logic signed [PW-1:0]    p_cdx_reg;
    logic                    p_ready;

    // result stage
    logic                    r_valid_reg;
    logic signed [OUT_W-1:0] r_cos_reg;
    logic signed [OUT_W-1:0] r_sin_reg;
    logic signed [OUT_W-1:0] r_a_reg;
    logic signed [OUT_W-1:0] r_b_reg;
    logic signed [SW-1:0]    sum_a;
    logic signed [SW-1:0]    sum_b;
    logic                    r_ready;

    // stall chain, a bubble is filled even while the output waits
    assign r_ready   = !r_valid_reg || ready_in;
    assign p_ready   = !p_valid_reg || r_ready;
    assign t_ready   = !t_valid_reg || p_ready;
    assign ready_out = t_ready;

    // undo the half-turn fold
    always_comb
    begin
        x_fold = data_in.flip ? -(XYW+1)'(data_in.x) : (XYW+1)'(data_in.x);
        y_fold = data_in.flip ? -(XYW+1)'(data_in.y) : (XYW+1)'(data_in.y);
    end

    // mixed sums of products
    always_comb
    begin
        sum_a = SW'(p_cdy_reg) - SW'(p_sdx_reg);
        sum_b = -SW'(p_sdy_reg) - SW'(p_cdx_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (t_ready)
                t_valid_reg <= valid_in;
            if (p_ready)
                p_valid_reg <= t_valid_reg;
            if (r_ready)
                r_valid_reg <= p_valid_reg;
        end
    end

    // clamp stage payload
    always_ff @(posedge clk)
    begin
        if (t_ready && valid_in)
        begin
            t_cos_reg <= clamp_one(x_fold);
            t_sin_reg <= clamp_one(y_fold);
            t_dx_reg  <= data_in.dx;
            t_dy_reg  <= data_in.dy;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (p_ready && t_valid_reg)
        begin
            p_cos_reg <= t_cos_reg;
            p_sin_reg <= t_sin_reg;
            p_cdy_reg <= t_cos_reg * t_dy_reg;
            p_sdx_reg <= t_sin_reg * t_dx_reg;
            p_sdy_reg <= t_sin_reg * t_dy_reg;
            p_cdx_reg <= t_cos_reg * t_dx_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (r_ready && p_valid_reg)
        begin
            r_cos_reg <= p_cos_reg;
            r_sin_reg <= p_sin_reg;
            r_a_reg   <= round_sat(sum_a);
            r_b_reg   <= round_sat(sum_b);
        end
    end

    assign cos_out   = r_cos_reg;
    assign sin_out   = r_sin_reg;
    assign mix_a     = r_a_reg;
    assign mix_b     = r_b_reg;
    assign valid_out = r_valid_reg;

endmodule

FILE: rtl/pose_landmark_jacobian_2d.sv
// top level of the pose/landmark observation jacobian pipeline
// depends on pljac_pkg, pljac_front, pljac_cordic_stage, pljac_mix, assert_macros.svh
//
// channel   handshake              payload
// -------   --------------------   ------------------------------------------
// input     in_valid / in_ready    pose_x, pose_y, pose_heading, point_x, point_y
// output    out_valid / out_ready  pose_jac_00..12, point_jac_00..11
//
// one transaction per cycle while out_ready stays high; a transaction passes the
// front stage, the chain of registered cordic rotation stages, then the clamp, product
// and round stages. rst_n clears every valid bit asynchronously, payload
// registers are not reset. a stall at the output holds the last stage, while
// empty stages upstream keep filling; in_ready drops only when every stage
// holds a transaction.
module pose_landmark_jacobian_2d #(
    parameter int TRIG_STAGES = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pljac_pkg::POS_W-1:0]  pose_x,
    input  logic signed [pljac_pkg::POS_W-1:0]  pose_y,
    input  logic signed [pljac_pkg::HDG_W-1:0]  pose_heading,
    input  logic signed [pljac_pkg::POS_W-1:0]  point_x,
    input  logic signed [pljac_pkg::POS_W-1:0]  point_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_00,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_01,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_02,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_10,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_11,
    output logic signed [pljac_pkg::OUT_W-1:0]  pose_jac_12,
    output logic signed [pljac_pkg::OUT_W-1:0]  point_jac_00,
    output logic signed [pljac_pkg::OUT_W-1:0]  point_jac_01,
    output logic signed [pljac_pkg::OUT_W-1:0]  point_jac_10,
    output logic signed [pljac_pkg::OUT_W-1:0]  point_jac_11
);
    import pljac_pkg::*;

    `include "assert_macros.svh"

    // bounds on c^2 + s^2 in Q4.60, loose enough for the shortest cordic
    localparam longint NORM_LO = 64'sd1152921504606846976 - 64'sd9007199254740992;
    localparam longint NORM_HI = 64'sd1152921504606846976 + 64'sd9007199254740992;

    cordic_t                 cord_data  [0:TRIG_STAGES];
    logic                    cord_valid [0:TRIG_STAGES];
    logic                    cord_ready [0:TRIG_STAGES];
    logic signed [OUT_W-1:0] cos_val;
    logic signed [OUT_W-1:0] sin_val;
    logic signed [OUT_W-1:0] mix_a;
    logic signed [OUT_W-1:0] mix_b;
    logic signed [63:0]      norm_sq;
    logic                    norm_ok;

    // fold and differences
    pljac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (in_valid),
        .ready_out    (in_ready),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .point_x      (point_x),
        .point_y      (point_y),
        .data_out     (cord_data[0]),
        .valid_out    (cord_valid[0]),
        .ready_in     (cord_ready[0])
    );

    // cordic rotation chain
    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_cordic
        pljac_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .data_in   (cord_data[i]),
            .valid_in  (cord_valid[i]),
            .ready_out (cord_ready[i]),
            .data_out  (cord_data[i+1]),
            .valid_out (cord_valid[i+1]),
            .ready_in  (cord_ready[i+1])
        );
    end

    // clamp, products, rounding
    pljac_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_in   (cord_data[TRIG_STAGES]),
        .valid_in  (cord_valid[TRIG_STAGES]),
        .ready_out (cord_ready[TRIG_STAGES]),
        .cos_out   (cos_val),
        .sin_out   (sin_val),
        .mix_a     (mix_a),
        .mix_b     (mix_b),
        .valid_out (out_valid),
        .ready_in  (out_ready)
    );

    // jacobian entries from c, s and the mixed terms
    assign pose_jac_00  = -cos_val;
    assign pose_jac_01  = -sin_val;
    assign pose_jac_02  = mix_a;
    assign pose_jac_10  = sin_val;
    assign pose_jac_11  = -cos_val;
    assign pose_jac_12  = mix_b;
    assign point_jac_00 = cos_val;
    assign point_jac_01 = sin_val;
    assign point_jac_10 = -sin_val;
    assign point_jac_11 = cos_val;

    // squared length of the trig pair, for checking only
    assign norm_sq = 64'(point_jac_00) * 64'(point_jac_00)
                   + 64'(point_jac_01) * 64'(point_jac_01);
    assign norm_ok = (norm_sq >= NORM_LO) && (norm_sq <= NORM_HI);

    // input backs up only when the whole pipe is full and the output stalls
    `ASSERT_IMPLY(a_full_stall, !in_ready, out_valid && !out_ready, "input stalled, pipe not full")

    // cordic result lies on the unit circle
    `ASSERT_IMPLY(a_unit_norm, out_valid, norm_ok, "trig terms off the unit circle")

    // no transaction leaves the first cycle after reset
    `ASSERT_AT_CLK(a_reset_empty, $past(!rst_n) |-> !out_valid, "output valid right after reset")

endmodule
